// ----- rtl/pamt_pkg.sv -----
// ----------------------------------------------------------------------------
// Prioritized address map table package
// Shared types, request and status codes, and cell commands.
// ----------------------------------------------------------------------------
package pamt_pkg;

	localparam int MAP_SLOTS_DEF = 16;
	localparam int ID_W = 9;

	localparam logic [2:0] REQ_ADD    = 3'd0;
	localparam logic [2:0] REQ_LOOKUP = 3'd1;
	localparam logic [2:0] REQ_DEL_ID = 3'd2;
	localparam logic [2:0] REQ_DEL_FD = 3'd3;
	localparam logic [2:0] REQ_PRIO   = 3'd4;
	localparam logic [2:0] REQ_EXISTS = 3'd5;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_BAD_RANGE = 2'd2;
	localparam logic [1:0] ST_NO_ID     = 2'd3;

	localparam logic [2:0] CMD_HOLD = 3'd0;
	localparam logic [2:0] CMD_ROT  = 3'd1;
	localparam logic [2:0] CMD_SQZ  = 3'd2;
	localparam logic [2:0] CMD_INS  = 3'd3;
	localparam logic [2:0] CMD_WR   = 3'd4;

	typedef struct packed {
		logic            vld;
		logic [ID_W-1:0] id;
		logic [15:0]     fd;
		logic [7:0]      flags;
		logic [63:0]     delta;
		logic [63:0]     first;
		logic [63:0]     last;
	} rec_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       sel;
	} cell_ctrl_t;

endpackage

// ----- rtl/prioritized_address_map_table.sv -----
// ----------------------------------------------------------------------------
// Prioritized address map table
// Ordered table of address maps with add, lookup, delete, prioritize and
// exists requests.
//
// A transaction is accepted at a clock edge where start is high and busy is
// low; busy stays high until the result is issued. The result appears on the
// result ports for one cycle with done high and cannot be held off.
// The maps sit in a row of cells in priority order, position 0 first.
// An add goes through its add step before done, and a reserved
// request type goes straight to the finish step. Lookup and exists
// rotate the whole row once through the head cell. A delete that
// removes a map adds a squeeze pass, and a prioritize that finds its
// map adds that pass and one insert step.
// One transaction is in work at a time. Reset empties the table, the
// freed id queue and the id counter; no clearing pass is needed.
// ----------------------------------------------------------------------------
module prioritized_address_map_table import pamt_pkg::*; #(
	parameter int MAP_SLOTS = MAP_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [63:0] address,
	input  logic [63:0] size,
	input  logic [63:0] delta,
	input  logic [15:0] fd,
	input  logic [7:0]  flags,
	input  logic [31:0] target_id,
	output logic        done,
	output logic [1:0]  status,
	output logic [8:0]  map_id,
	output logic [15:0] map_fd,
	output logic [7:0]  map_flags,
	output logic [63:0] map_delta,
	output logic [63:0] map_start,
	output logic [63:0] map_end
);

	localparam int LW = $clog2(MAP_SLOTS + 1);
	localparam int CNW = (MAP_SLOTS > 1) ? $clog2(MAP_SLOTS) : 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ADD  = 3'd1;
	localparam logic [2:0] S_ROT  = 3'd2;
	localparam logic [2:0] S_SQZ  = 3'd3;
	localparam logic [2:0] S_INS  = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	logic [2:0]      state_q;
	logic [CNW-1:0]  cnt_q;
	logic [2:0]      req_q;
	logic [63:0]     addr_q;
	logic [63:0]     size_q;
	logic [63:0]     delta_q;
	logic [15:0]     fd_q;
	logic [7:0]      flags_q;
	logic [31:0]     tgt_q;
	logic            found_q;
	logic [1:0]      astat_q;
	rec_t            cap_q;
	rec_t            hold_q;
	logic [LW-1:0]   live_q;
	logic [ID_W-1:0] ctr_q;
	logic            done_q;

	rec_t            recs [MAP_SLOTS];
	logic [MAP_SLOTS:0] holes;
	logic [MAP_SLOTS-1:0] vlds;
	cell_ctrl_t      ctrls [MAP_SLOTS];
	logic [2:0]      cmd;
	rec_t            head;
	rec_t            tail_in;
	rec_t            new_rec;
	logic            id_hit;
	logic            in_rng;
	logic            hit;
	logic            drop;
	logic            bad;
	logic            freed_nz;
	logic            add_ok;
	logic [ID_W-1:0] new_id;
	logic [ID_W-1:0] q_head_id;
	logic [LW-1:0]   q_level;
	logic            cnt_last;
	logic            okf;

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign head = recs[0];
	assign cnt_last = (cnt_q == CNW'(MAP_SLOTS - 1));

	assign id_hit = head.vld && (32'(head.id) == tgt_q);
	assign in_rng = head.vld && (head.first <= addr_q) && (head.last >= addr_q);

	always_comb begin
		case (req_q)
			REQ_LOOKUP: hit = in_rng && !found_q;
			REQ_DEL_ID: hit = id_hit && !found_q;
			REQ_PRIO:   hit = id_hit && !found_q;
			REQ_EXISTS: hit = id_hit && !found_q;
			REQ_DEL_FD: hit = head.vld && (head.fd == fd_q);
			default:    hit = 1'b0;
		endcase
	end

	assign drop = (state_q == S_ROT) && hit &&
		(req_q == REQ_DEL_ID || req_q == REQ_DEL_FD || req_q == REQ_PRIO);

	assign bad = (size_q == 64'd0) || (addr_q > (64'd0 - size_q));
	assign freed_nz = (q_level != '0);
	assign add_ok = !bad && (freed_nz || (ctr_q < ID_W'(MAP_SLOTS)));
	assign new_id = freed_nz ? q_head_id : ctr_q + 1'b1;

	always_comb begin
		new_rec.vld = 1'b1;
		new_rec.id = new_id;
		new_rec.fd = fd_q;
		new_rec.flags = flags_q;
		new_rec.delta = delta_q;
		new_rec.first = addr_q;
		new_rec.last = addr_q + size_q - 64'd1;
	end

	always_comb begin
		tail_in = '0;
		if (state_q == S_ROT) begin
			tail_in = head;
			tail_in.vld = head.vld && !drop;
		end
	end

	always_comb begin
		case (state_q)
			S_ROT:   cmd = CMD_ROT;
			S_SQZ:   cmd = CMD_SQZ;
			S_INS:   cmd = CMD_INS;
			S_ADD:   cmd = add_ok ? CMD_WR : CMD_HOLD;
			default: cmd = CMD_HOLD;
		endcase
	end

	assign holes[0] = 1'b0;

	genvar gi;
	generate
		for (gi = 0; gi < MAP_SLOTS; gi++) begin : g_cell
			rec_t nxt;
			rec_t prv;
			if (gi == MAP_SLOTS - 1) begin : g_last
				assign nxt = tail_in;
			end else begin : g_mid
				assign nxt = recs[gi+1];
			end
			if (gi == 0) begin : g_first
				assign prv = hold_q;
			end else begin : g_rest
				assign prv = recs[gi-1];
			end
			assign ctrls[gi].cmd = cmd;
			assign ctrls[gi].sel = (live_q == LW'(gi));
			assign vlds[gi] = recs[gi].vld;
			pamt_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrls[gi]),
				.next_rec (nxt),
				.prev_rec (prv),
				.new_rec  (new_rec),
				.hole_in  (holes[gi]),
				.hole_out (holes[gi+1]),
				.rec      (recs[gi])
			);
		end
	endgenerate

	pamt_idq #(
		.DEPTH (MAP_SLOTS)
	) u_idq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (drop && (req_q != REQ_PRIO)),
		.push_id (head.id),
		.pop     ((state_q == S_ADD) && add_ok && freed_nz),
		.head_id (q_head_id),
		.level   (q_level)
	);

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q <= req_type;
			addr_q <= address;
			size_q <= size;
			delta_q <= delta;
			fd_q <= fd;
			flags_q <= flags;
			tgt_q <= target_id;
		end
		if (state_q == S_ADD && add_ok) begin
			cap_q <= new_rec;
		end else if (state_q == S_ROT && hit && !found_q) begin
			cap_q <= head;
		end
		if (state_q == S_ROT && hit && req_q == REQ_PRIO) begin
			hold_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			found_q <= 1'b0;
			astat_q <= ST_NOT_FOUND;
			live_q <= '0;
			ctr_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == S_FIN);
			case (state_q)
				S_IDLE: begin
					if (start) begin
						found_q <= 1'b0;
						cnt_q <= '0;
						astat_q <= ST_NOT_FOUND;
						if (req_type == REQ_ADD) begin
							state_q <= S_ADD;
						end else if (req_type <= REQ_EXISTS) begin
							state_q <= S_ROT;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_ADD: begin
					if (bad) begin
						astat_q <= ST_BAD_RANGE;
					end else if (add_ok) begin
						astat_q <= ST_OK;
						found_q <= 1'b1;
						live_q <= live_q + 1'b1;
						if (!freed_nz) begin
							ctr_q <= ctr_q + 1'b1;
						end
					end else begin
						astat_q <= ST_NO_ID;
					end
					state_q <= S_FIN;
				end
				S_ROT: begin
					if (hit) begin
						found_q <= 1'b1;
					end
					if (drop) begin
						live_q <= live_q - 1'b1;
					end
					if (cnt_last) begin
						cnt_q <= '0;
						if ((found_q || hit) && (req_q == REQ_DEL_ID ||
							req_q == REQ_DEL_FD || req_q == REQ_PRIO)) begin
							state_q <= S_SQZ;
						end else begin
							state_q <= S_FIN;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_SQZ: begin
					if (cnt_last) begin
						cnt_q <= '0;
						state_q <= (req_q == REQ_PRIO) ? S_INS : S_FIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_INS: begin
					live_q <= live_q + 1'b1;
					state_q <= S_FIN;
				end
				S_FIN: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign okf = found_q && (req_q != REQ_DEL_FD);

	always_comb begin
		if (req_q == REQ_ADD) begin
			status = astat_q;
		end else begin
			status = found_q ? ST_OK : ST_NOT_FOUND;
		end
		map_id = okf ? cap_q.id : '0;
		map_fd = okf ? cap_q.fd : '0;
		map_flags = okf ? cap_q.flags : '0;
		map_delta = okf ? cap_q.delta : '0;
		map_start = okf ? cap_q.first : '0;
		map_end = okf ? cap_q.last : '0;
	end

`ifndef NO_ASSERTIONS
	a_live_range: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= LW'(MAP_SLOTS))
		else $error("Live map count exceeds the table size.");

	a_live_cells: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> $countones(vlds) == 32'(live_q))
		else $error("Live map count disagrees with the valid cells.");

	a_ids_kept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> (32'(live_q) + 32'(q_level)) == 32'(ctr_q))
		else $error("Issued ids are neither live nor queued as freed.");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("Result strobe lasted more than one cycle.");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("Accepted transaction did not raise busy.");
`endif

endmodule

// ----- rtl/pamt_cell.sv -----
// ----------------------------------------------------------------------------
// Map table cell
// Holds one map at one priority position and moves it to a neighbor on command.
// ----------------------------------------------------------------------------
module pamt_cell import pamt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  rec_t       next_rec,
	input  rec_t       prev_rec,
	input  rec_t       new_rec,
	input  logic       hole_in,
	output logic       hole_out,
	output rec_t       rec
);

	rec_t rec_q;

	assign hole_out = hole_in | ~rec_q.vld;
	assign rec = rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else begin
			case (ctrl.cmd)
				CMD_ROT: begin
					rec_q <= next_rec;
				end
				CMD_SQZ: begin
					if (hole_out) begin
						rec_q <= next_rec;
					end
				end
				CMD_INS: begin
					rec_q <= prev_rec;
				end
				CMD_WR: begin
					if (ctrl.sel) begin
						rec_q <= new_rec;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- rtl/pamt_idq.sv -----
// ----------------------------------------------------------------------------
// Freed id queue
// First-in first-out store of ids released by deletions.
// ----------------------------------------------------------------------------
module pamt_idq import pamt_pkg::*; #(
	parameter int DEPTH = MAP_SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [ID_W-1:0]            push_id,
	input  logic                       pop,
	output logic [ID_W-1:0]            head_id,
	output logic [$clog2(DEPTH+1)-1:0] level
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [ID_W-1:0] mem [DEPTH];
	logic [AW-1:0]   head_q;
	logic [AW-1:0]   tail_q;
	logic [CW-1:0]   cnt_q;
	logic [ID_W-1:0] rd_q;
	logic            do_push;

	assign do_push = push && (cnt_q != CW'(DEPTH));
	assign head_id = rd_q;
	assign level = cnt_q;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[tail_q] <= push_id;
		end
		rd_q <= mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				tail_q <= (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
			end
			if (pop) begin
				head_q <= (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			if (do_push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// Prioritized address map table testbench
// Drives directed and random add, lookup, delete, prioritize and exists
// requests, keeps its own copy of the table and checks every result field.
// ----------------------------------------------------------------------------
module tb;
	import pamt_pkg::*;

	localparam int SLOTS = 16;
	localparam int N_RANDOM = 2000;

	typedef struct {
		logic [2:0]  rq;
		logic [63:0] adr;
		logic [63:0] sz;
		logic [63:0] dl;
		logic [15:0] fdn;
		logic [7:0]  fl;
		logic [31:0] tid;
		bit          drain;
	} req_t;

	typedef struct {
		logic [1:0]  st;
		logic [8:0]  id;
		logic [15:0] fdn;
		logic [7:0]  fl;
		logic [63:0] dl;
		logic [63:0] lo;
		logic [63:0] hi;
	} res_t;

	logic clk = 0, arst_n = 0, start = 0;
	logic busy, done;
	logic [2:0] req_type = 0;
	logic [63:0] address = 0, size = 0, delta = 0;
	logic [15:0] fd = 0;
	logic [7:0] flags = 0;
	logic [31:0] target_id = 0;
	logic [1:0] status;
	logic [8:0] map_id;
	logic [15:0] map_fd;
	logic [7:0] map_flags;
	logic [63:0] map_delta, map_start, map_end;

	prioritized_address_map_table dut (.*);

	always #5 clk = ~clk;

	req_t pending[$];
	res_t expected_results[$];
	req_t cur;
	int gap = 0;
	bit idle_on = 1;
	int errors = 0;

	logic [63:0] tbl_lo[SLOTS], tbl_hi[SLOTS], tbl_dl[SLOTS];
	logic [15:0] tbl_fd[SLOTS];
	logic [7:0]  tbl_fl[SLOTS];
	int tbl_id[SLOTS], order[SLOTS], freed[SLOTS];
	int n_live = 0, freed_hd = 0, n_freed = 0, id_ctr = 0;

	function automatic res_t record_of(int s);
		res_t r;
		r.st = ST_OK;
		r.id = 9'(tbl_id[s]);
		r.fdn = tbl_fd[s];
		r.fl = tbl_fl[s];
		r.dl = tbl_dl[s];
		r.lo = tbl_lo[s];
		r.hi = tbl_hi[s];
		return r;
	endfunction

	function automatic int position_of(logic [31:0] id);
		for (int k = 0; k < n_live; k++)
			if (tbl_id[order[k]] == id)
				return k;
		return -1;
	endfunction

	function automatic void release_at(int p);
		if (n_freed < SLOTS) begin
			freed[(freed_hd + n_freed) % SLOTS] = tbl_id[order[p]];
			n_freed++;
		end
		for (int k = p; k + 1 < n_live; k++)
			order[k] = order[k + 1];
		n_live--;
	endfunction

	function automatic res_t apply_request(req_t q);
		res_t r;
		int p, s, id;
		r = '{ST_NOT_FOUND, 0, 0, 0, 0, 0, 0};
		case (q.rq)
			REQ_ADD: begin
				if (q.sz == 0 || q.adr > 64'd0 - q.sz) begin
					r.st = ST_BAD_RANGE;
				end else if (n_freed == 0 && id_ctr >= SLOTS) begin
					r.st = ST_NO_ID;
				end else begin
					if (n_freed > 0) begin
						id = freed[freed_hd];
						freed_hd = (freed_hd + 1) % SLOTS;
						n_freed--;
					end else begin
						id_ctr++;
						id = id_ctr;
					end
					s = id - 1;
					tbl_id[s] = id;
					tbl_fd[s] = q.fdn;
					tbl_fl[s] = q.fl;
					tbl_dl[s] = q.dl;
					tbl_lo[s] = q.adr;
					tbl_hi[s] = q.adr + q.sz - 64'd1;
					if (n_live < SLOTS) begin
						order[n_live] = s;
						n_live++;
					end
					r = record_of(s);
				end
			end
			REQ_LOOKUP: begin
				for (int k = 0; k < n_live; k++) begin
					s = order[k];
					if (tbl_lo[s] <= q.adr && tbl_hi[s] >= q.adr) begin
						r = record_of(s);
						break;
					end
				end
			end
			REQ_DEL_ID: begin
				p = position_of(q.tid);
				if (p >= 0) begin
					r = record_of(order[p]);
					release_at(p);
				end
			end
			REQ_DEL_FD: begin
				p = 0;
				while (p < n_live) begin
					if (tbl_fd[order[p]] == q.fdn) begin
						r.st = ST_OK;
						release_at(p);
					end else begin
						p++;
					end
				end
			end
			REQ_PRIO: begin
				p = position_of(q.tid);
				if (p >= 0) begin
					s = order[p];
					for (int k = p; k > 0; k--)
						order[k] = order[k - 1];
					order[0] = s;
					r = record_of(s);
				end
			end
			REQ_EXISTS: begin
				p = position_of(q.tid);
				if (p >= 0)
					r = record_of(order[p]);
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic report(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		bit nxt;
		if (!arst_n) begin
			start <= 0;
		end else begin
			nxt = start;
			if (start && !busy) begin
				expected_results.push_back(apply_request(cur));
				nxt = 0;
				if (idle_on && pending.size() > 150 && $urandom_range(0, 3) == 0)
					gap = $urandom_range(1, 19);
			end
			if (!nxt) begin
				if (gap > 0) begin
					gap--;
				end else if (pending.size() > 0 &&
						!(pending[0].drain && expected_results.size() > 0)) begin
					cur = pending.pop_front();
					req_type <= cur.rq;
					address <= cur.adr;
					size <= cur.sz;
					delta <= cur.dl;
					fd <= cur.fdn;
					flags <= cur.fl;
					target_id <= cur.tid;
					nxt = 1;
				end
			end
			start <= nxt;
		end
	end

	always @(posedge clk) begin
		res_t e;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				report("transaction result with nothing expected");
			end else begin
				e = expected_results.pop_front();
				if (status !== e.st)
					report($sformatf("status %0d, expected %0d", status, e.st));
				if (map_id !== e.id)
					report($sformatf("map_id %0d, expected %0d", map_id, e.id));
				if (map_fd !== e.fdn)
					report($sformatf("map_fd %h, expected %h", map_fd, e.fdn));
				if (map_flags !== e.fl)
					report($sformatf("map_flags %h, expected %h", map_flags, e.fl));
				if (map_delta !== e.dl)
					report($sformatf("map_delta %h, expected %h", map_delta, e.dl));
				if (map_start !== e.lo)
					report($sformatf("map_start %h, expected %h", map_start, e.lo));
				if (map_end !== e.hi)
					report($sformatf("map_end %h, expected %h", map_end, e.hi));
			end
		end
	end

	function automatic req_t make_req(logic [2:0] rq, logic [63:0] adr, logic [63:0] sz,
			logic [15:0] fdn, logic [31:0] tid);
		req_t q;
		q.rq = rq;
		q.adr = adr;
		q.sz = sz;
		q.dl = {$urandom, $urandom};
		q.fdn = fdn;
		q.fl = 8'($urandom);
		q.tid = tid;
		q.drain = 0;
		return q;
	endfunction

	function automatic req_t random_req(int add_weight);
		req_t q;
		logic [63:0] a, s;
		int pick;
		a = $urandom_range(0, 15) * 64'h1000 + 64'($urandom_range(0, 4095));
		s = 64'($urandom_range(1, 8192));
		if ($urandom_range(0, 9) == 0) a = {$urandom, $urandom};
		if ($urandom_range(0, 9) == 0) s = {$urandom, $urandom};
		if ($urandom_range(0, 29) == 0) s = 0;
		q = make_req(REQ_LOOKUP, a, s, 16'($urandom_range(0, 3)),
			$urandom_range(0, 12) == 0 ? $urandom : $urandom_range(0, 17));
		if ($urandom_range(0, 7) == 0) q.fdn = 16'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < add_weight) q.rq = REQ_ADD;
		else if (pick < add_weight + (100 - add_weight) * 2 / 5) q.rq = REQ_LOOKUP;
		else if (pick < 97) q.rq = 3'($urandom_range(REQ_DEL_ID, REQ_EXISTS));
		else q.rq = 3'($urandom_range(6, 7));
		return q;
	endfunction

	initial begin
		req_t q;
		int w;
		logic [63:0] ones;
		ones = '1;
		pending.push_back(make_req(REQ_ADD, 0, 0, 0, 0));
		pending.push_back(make_req(REQ_ADD, ones, 1, 16'hffff, 0));
		pending.push_back(make_req(REQ_ADD, ones, 2, 1, 0));
		pending.push_back(make_req(REQ_ADD, 0, ones, 0, 0));
		pending.push_back(make_req(REQ_ADD, 1, ones, 1, 0));
		pending.push_back(make_req(REQ_ADD, 64'h1000, 64'h100, 1, 0));
		pending.push_back(make_req(REQ_LOOKUP, ones, 0, 0, 0));
		pending.push_back(make_req(REQ_LOOKUP, 64'h1080, 0, 0, 0));
		pending.push_back(make_req(REQ_LOOKUP, 0, 0, 0, 0));
		pending.push_back(make_req(REQ_EXISTS, 0, 0, 0, 1));
		pending.push_back(make_req(REQ_EXISTS, 0, 0, 0, 0));
		pending.push_back(make_req(REQ_PRIO, 0, 0, 0, 3));
		pending.push_back(make_req(REQ_LOOKUP, 64'h1080, 0, 0, 0));
		pending.push_back(make_req(REQ_PRIO, 0, 0, 0, 32'hffffffff));
		pending.push_back(make_req(REQ_DEL_ID, 0, 0, 0, 1));
		pending.push_back(make_req(REQ_DEL_ID, 0, 0, 0, 32'hffffffff));
		pending.push_back(make_req(REQ_DEL_FD, 0, 0, 1, 0));
		pending.push_back(make_req(REQ_DEL_FD, 0, 0, 16'h7777, 0));
		pending.push_back(make_req(3'd6, ones, ones, 16'hffff, 32'hffffffff));
		pending.push_back(make_req(3'd7, 0, 0, 0, 0));
		pending.push_back(make_req(REQ_ADD, 64'h2000, 64'h10, 2, 0));
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 100 == 0) w = $urandom_range(0, 2) == 0 ? 70 : $urandom_range(15, 45);
			q = random_req(w);
			if (i == N_RANDOM / 2) q.drain = 1;
			pending.push_back(q);
		end
		repeat (5) @(posedge clk);
		arst_n <= 1;
		while (pending.size() > 0 || start || expected_results.size() > 0) begin
			if (pending.size() > 0 && pending.size() % 400 == 0)
				idle_on = ~idle_on;
			@(posedge clk);
		end
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#5000000;
		$display("FAIL");
		$finish;
	end

endmodule
